[src/vehicle_pid_throttle_brake_steer_assert.svh]
// assertion macros shared by the vehicle pid controller rtl
`ifndef VEHICLE_PID_THROTTLE_BRAKE_STEER_ASSERT_SVH
`define VEHICLE_PID_THROTTLE_BRAKE_STEER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define VPID_ASSERT_IMPLIES(label, clock, resetn, ante, cons) \
  label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
    else $error("vpid assertion failed");

// next-cycle implication, disabled while in reset
`define VPID_ASSERT_NEXT(label, clock, resetn, ante, cons) \
  label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
    else $error("vpid assertion failed");

`endif

[src/vpid_pkg.sv]
// types and constants shared by the vehicle pid controller
package vpid_pkg;

  localparam int LIM_W = 15;
  localparam int FRAC_SHIFT = 9;
  localparam int DIRECT_SHIFT = 8;
  localparam logic [15:0] STEPS_RESET = 16'd20;

  // q8.8 gains, kp in the low bits
  typedef struct packed {
    logic [15:0] kd;
    logic [15:0] ki;
    logic [15:0] kp;
  } gains_t;

  typedef enum logic [2:0] {
    REG_THR_GAINS   = 3'd0,
    REG_BRK_GAINS   = 3'd1,
    REG_STR_GAINS   = 3'd2,
    REG_DEADZONES   = 3'd3,
    REG_THR_LIMITS  = 3'd4,
    REG_BRK_LIMITS  = 3'd5,
    REG_STR_LIMITS  = 3'd6,
    REG_INTEG_STEPS = 3'd7
  } cfg_reg_t;

endpackage

[src/vehicle_pid_throttle_brake_steer.sv]
// top level of the throttle, brake and steering pid controller
//
//  channel | direction | handshake            | word
//  in_     | slave     | in_tvalid/in_tready  | tdata: targets and measurements, tuser: direct mode
//  out_    | master    | out_tvalid/out_tready| tdata: throttle, brake, steer
//  cfg_    | slave     | cfg_valid/cfg_ready  | register index and data, always ready
//
// one word per cycle sustained while out_tready is high; a word waits in the input register and
// then the whole pid pass (three parallel multiplier sets) runs into the result register.
// the controller state is updated in the same cycle the result register loads.
// a stalled output holds its word; the input register still drains when the result is taken.
// rst_n is synchronous; config resets to zero except the integrator period of 20.
`include "vehicle_pid_throttle_brake_steer_assert.svh"

module vehicle_pid_throttle_brake_steer #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int INTEGRATOR_WIDTH = 32,
  parameter int COUNTER_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // target_accel, measured_accel, target_steer, measured_steer
  input  logic [63:0] in_tdata,
  // direct_mode
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // throttle_out, brake_out, steer_out, two zero pad bits
  output logic [47:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [47:0] cfg_data
);

  localparam int EW = SAMPLE_WIDTH;
  localparam int IW = INTEGRATOR_WIDTH;
  localparam int CW = COUNTER_WIDTH;
  localparam int XW = (EW > 17) ? EW : 17;
  localparam int DW = EW + 3;
  localparam int AW = ((IW > EW) ? IW : EW) + 1;
  localparam int SUMW = (((EW + 20) > 43) ? EW + 20 : 43) + 2;
  localparam int VW = SUMW + 1;
  localparam int CMPW = ((EW > 16) ? EW : 16) + 2;
  localparam int NW = ((CW + 1) > 16) ? CW + 1 : 16;
  localparam int LW = vpid_pkg::LIM_W;

  localparam logic signed [XW-1:0] EHI = {{(XW-EW+1){1'b0}}, {(EW-1){1'b1}}};
  localparam logic signed [XW-1:0] ELO = {{(XW-EW+1){1'b1}}, {(EW-1){1'b0}}};
  localparam logic signed [AW-1:0] IHI = {{(AW-IW+1){1'b0}}, {(IW-1){1'b1}}};
  localparam logic signed [AW-1:0] ILO = {{(AW-IW+1){1'b1}}, {(IW-1){1'b0}}};

  // configuration
  vpid_pkg::gains_t thr_gains_r, brk_gains_r, str_gains_r;
  logic [47:0] deadzones_r;
  logic [31:0] thr_lim_r, brk_lim_r, str_lim_r;
  logic [15:0] steps_r;

  // input register
  logic               in_valid_r;
  logic signed [15:0] in_ta_r, in_ma_r, in_ts_r, in_ms_r;
  logic               in_dir_r;

  // controller state
  logic signed [EW-1:0] ah0_r, ah1_r, sh0_r, sh1_r;
  logic [1:0]           fill_r;
  logic [CW-1:0]        cnt_r;
  logic signed [IW-1:0] ai_r, si_r;
  logic [LW-1:0]        thr_r, brk_r;
  logic signed [15:0]   str_r;
  logic                 brake_rest_r;

  // result register
  logic          out_valid_r;
  logic [LW-1:0] out_thr_r, out_brk_r;
  logic [15:0]   out_str_r;

  logic adv;

  logic signed [16:0]     diff_a, diff_s;
  logic signed [EW-1:0]   ea, es;
  logic [1:0]             fill_nxt;
  logic signed [DW-1:0]   da, ds;
  logic signed [IW-1:0]   ai_nxt, si_nxt;
  logic signed [SUMW-1:0] s_thr, s_brk, s_str;
  logic signed [VW-1:0]   v_thr, v_brk, neg_brk, v_str, v_dir;
  logic signed [32:0]     dir_prod;
  logic signed [15:0]     dz_thr, dz_brk, dz_str;
  logic signed [CMPW-1:0] es_mag;
  logic                   thr_on, brk_on, str_on;
  logic [LW-1:0]          thr_nxt, brk_nxt, brk_show;
  logic signed [15:0]     str_nxt;
  logic                   brake_rest_nxt;
  logic [NW-1:0]          cnt_inc;
  logic [CW-1:0]          cnt_nxt;

  function automatic logic signed [EW-1:0] sat_err(input logic signed [16:0] d);
    logic signed [XW-1:0] dx;
    dx = XW'(d);
    if (dx > EHI) begin
      return EHI[EW-1:0];
    end else if (dx < ELO) begin
      return ELO[EW-1:0];
    end
    return dx[EW-1:0];
  endfunction

  // backward difference, order set by how many errors have been seen
  function automatic logic signed [DW-1:0] deriv(input logic [1:0] fill,
                                                 input logic signed [EW-1:0] h1,
                                                 input logic signed [EW-1:0] h0,
                                                 input logic signed [EW-1:0] e);
    logic signed [DW-1:0] e3;
    e3 = DW'(e);
    if (fill == 2'd3) begin
      return DW'(h1) - (DW'(h0) <<< 2) + e3 + (e3 <<< 1);
    end else if (fill == 2'd2) begin
      return (e3 - DW'(h0)) <<< 1;
    end
    return '0;
  endfunction

  function automatic logic signed [IW-1:0] sat_int(input logic signed [IW-1:0] i,
                                                   input logic signed [EW-1:0] e);
    logic signed [AW-1:0] s;
    s = AW'(i) + AW'(e);
    if (s > IHI) begin
      return IHI[IW-1:0];
    end else if (s < ILO) begin
      return ILO[IW-1:0];
    end
    return s[IW-1:0];
  endfunction

  function automatic logic [LW-1:0] cut_u(input logic signed [VW-1:0] v,
                                          input logic [31:0] lim);
    logic signed [VW-1:0] mn, mx;
    mn = $signed({{(VW-LW){1'b0}}, lim[LW-1:0]});
    mx = $signed({{(VW-LW){1'b0}}, lim[LW+15:16]});
    if (!(v > mn)) begin
      return '0;
    end else if (v < mx) begin
      return v[LW-1:0];
    end
    return lim[LW+15:16];
  endfunction

  function automatic logic signed [15:0] cut_s(input logic signed [VW-1:0] v,
                                               input logic [31:0] lim);
    logic signed [VW-1:0] mn, mx, mag;
    mn = $signed({{(VW-LW){1'b0}}, lim[LW-1:0]});
    mx = $signed({{(VW-LW){1'b0}}, lim[LW+15:16]});
    mag = v[VW-1] ? -v : v;
    if (!(mag > mn)) begin
      return '0;
    end else if (mag > mx) begin
      return v[VW-1] ? -$signed({1'b0, lim[LW+15:16]}) : $signed({1'b0, lim[LW+15:16]});
    end
    return v[15:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign adv = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  assign out_tvalid = out_valid_r;
  assign out_tdata = {2'b00, out_str_r, out_brk_r, out_thr_r};

  // errors, derivatives, integrators
  assign diff_a = 17'(in_ta_r) - 17'(in_ma_r);
  assign diff_s = 17'(in_ts_r) - 17'(in_ms_r);
  assign ea = sat_err(diff_a);
  assign es = sat_err(diff_s);
  assign fill_nxt = (fill_r == 2'd3) ? 2'd3 : fill_r + 2'd1;
  assign da = deriv(fill_nxt, ah1_r, ah0_r, ea);
  assign ds = deriv(fill_nxt, sh1_r, sh0_r, es);
  assign ai_nxt = (cnt_r == '0) ? '0 : sat_int(ai_r, ea);
  assign si_nxt = (cnt_r == '0) ? '0 : sat_int(si_r, es);

  vpid_term #(.EW(EW), .IW(IW), .SUMW(SUMW)) u_thr (
    .gains(thr_gains_r), .err(ea), .integ(ai_nxt), .deriv(da), .sum(s_thr)
  );

  vpid_term #(.EW(EW), .IW(IW), .SUMW(SUMW)) u_brk (
    .gains(brk_gains_r), .err(ea), .integ(ai_nxt), .deriv(da), .sum(s_brk)
  );

  vpid_term #(.EW(EW), .IW(IW), .SUMW(SUMW)) u_str (
    .gains(str_gains_r), .err(es), .integ(si_nxt), .deriv(ds), .sum(s_str)
  );

  // floor to q4.12; brake is negated first
  assign v_thr = VW'(s_thr >>> vpid_pkg::FRAC_SHIFT);
  assign neg_brk = -VW'(s_brk);
  assign v_brk = neg_brk >>> vpid_pkg::FRAC_SHIFT;
  assign dir_prod = $signed({1'b0, str_gains_r.kp}) * in_ts_r;
  assign v_dir = VW'(dir_prod >>> vpid_pkg::DIRECT_SHIFT);
  assign v_str = in_dir_r ? v_dir : VW'(s_str >>> vpid_pkg::FRAC_SHIFT);

  assign dz_thr = deadzones_r[15:0];
  assign dz_brk = deadzones_r[31:16];
  assign dz_str = deadzones_r[47:32];
  assign es_mag = es[EW-1] ? -CMPW'(es) : CMPW'(es);
  assign thr_on = CMPW'(ea) > CMPW'(dz_thr);
  assign brk_on = !thr_on && (CMPW'(ea) < CMPW'(dz_brk));
  assign str_on = in_dir_r || (es_mag > CMPW'(dz_str));

  always_comb begin
    thr_nxt = thr_r;
    brk_nxt = brk_r;
    brake_rest_nxt = brake_rest_r;
    if (thr_on) begin
      brk_nxt = '0;
      brake_rest_nxt = 1'b0;
      thr_nxt = cut_u(v_thr, thr_lim_r);
    end else if (brk_on) begin
      thr_nxt = '0;
      brake_rest_nxt = 1'b0;
      brk_nxt = cut_u(v_brk, brk_lim_r);
    end
    str_nxt = str_on ? cut_s(v_str, str_lim_r) : str_r;
    brk_show = brake_rest_nxt ? brk_lim_r[LW+15:16] : brk_nxt;
  end

  // period counter wraps on reaching the configured step count
  assign cnt_inc = NW'(cnt_r) + NW'(1);
  assign cnt_nxt = (cnt_inc >= NW'(steps_r)) ? '0 : cnt_inc[CW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_gains_r <= '0;
      brk_gains_r <= '0;
      str_gains_r <= '0;
      deadzones_r <= '0;
      thr_lim_r <= '0;
      brk_lim_r <= '0;
      str_lim_r <= '0;
      steps_r <= vpid_pkg::STEPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (vpid_pkg::cfg_reg_t'(cfg_addr))
        vpid_pkg::REG_THR_GAINS: begin
          thr_gains_r <= vpid_pkg::gains_t'(cfg_data);
        end
        vpid_pkg::REG_BRK_GAINS: begin
          brk_gains_r <= vpid_pkg::gains_t'(cfg_data);
        end
        vpid_pkg::REG_STR_GAINS: begin
          str_gains_r <= vpid_pkg::gains_t'(cfg_data);
        end
        vpid_pkg::REG_DEADZONES: begin
          deadzones_r <= cfg_data;
        end
        vpid_pkg::REG_THR_LIMITS: begin
          thr_lim_r <= cfg_data[31:0];
        end
        vpid_pkg::REG_BRK_LIMITS: begin
          brk_lim_r <= cfg_data[31:0];
        end
        vpid_pkg::REG_STR_LIMITS: begin
          str_lim_r <= cfg_data[31:0];
        end
        vpid_pkg::REG_INTEG_STEPS: begin
          steps_r <= cfg_data[15:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      ah0_r <= '0;
      ah1_r <= '0;
      sh0_r <= '0;
      sh1_r <= '0;
      fill_r <= '0;
      cnt_r <= '0;
      ai_r <= '0;
      si_r <= '0;
      thr_r <= '0;
      brk_r <= '0;
      str_r <= '0;
      brake_rest_r <= 1'b1;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (adv) begin
        ah1_r <= ah0_r;
        ah0_r <= ea;
        sh1_r <= sh0_r;
        sh0_r <= es;
        fill_r <= fill_nxt;
        cnt_r <= cnt_nxt;
        ai_r <= ai_nxt;
        si_r <= si_nxt;
        thr_r <= thr_nxt;
        brk_r <= brk_nxt;
        str_r <= str_nxt;
        brake_rest_r <= brake_rest_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_ta_r <= in_tdata[15:0];
      in_ma_r <= in_tdata[31:16];
      in_ts_r <= in_tdata[47:32];
      in_ms_r <= in_tdata[63:48];
      in_dir_r <= in_tuser;
    end
    if (adv) begin
      out_thr_r <= thr_nxt;
      out_brk_r <= brk_show;
      out_str_r <= str_nxt;
    end
  end

  // throttle and brake are never driven together
  `VPID_ASSERT_IMPLIES(a_thr_brk_excl, clk, rst_n, out_valid_r, (out_thr_r == '0) || (out_brk_r == '0))
  `VPID_ASSERT_IMPLIES(a_rest_no_thr, clk, rst_n, brake_rest_r, thr_r == '0)
  `VPID_ASSERT_IMPLIES(a_rest_fall, clk, rst_n, $fell(brake_rest_r), $past(adv))
  `VPID_ASSERT_NEXT(a_adv_out, clk, rst_n, adv, out_valid_r)

endmodule

[src/vpid_term.sv]
// pid sum: 2*kp*e + 2*clamp(ki*i) + kd*d in units of 2^-21
module vpid_term #(
  parameter int EW = 16,
  parameter int IW = 32,
  parameter int SUMW = 45
) (
  input  vpid_pkg::gains_t        gains,
  input  logic signed [EW-1:0]    err,
  input  logic signed [IW-1:0]    integ,
  input  logic signed [EW+2:0]    deriv,
  output logic signed [SUMW-1:0]  sum
);

  localparam int CLW = (IW + 17 > 42) ? IW + 17 : 42;
  localparam logic signed [CLW-1:0] ILIM_HI = {{(CLW-41){1'b0}}, 1'b1, {40{1'b0}}};
  localparam logic signed [CLW-1:0] ILIM_LO = -ILIM_HI;

  logic signed [16:0]     kp_s;
  logic signed [16:0]     ki_s;
  logic signed [16:0]     kd_s;
  logic signed [EW+16:0]  p_prod;
  logic signed [IW+16:0]  i_prod;
  logic signed [CLW-1:0]  i_ext;
  logic signed [41:0]     i_sat;
  logic signed [EW+19:0]  d_prod;

  assign kp_s = $signed({1'b0, gains.kp});
  assign ki_s = $signed({1'b0, gains.ki});
  assign kd_s = $signed({1'b0, gains.kd});

  assign p_prod = kp_s * err;
  assign i_prod = ki_s * integ;
  assign d_prod = kd_s * deriv;

  assign i_ext = CLW'(i_prod);

  always_comb begin
    if (i_ext > ILIM_HI) begin
      i_sat = ILIM_HI[41:0];
    end else if (i_ext < ILIM_LO) begin
      i_sat = ILIM_LO[41:0];
    end else begin
      i_sat = i_ext[41:0];
    end
  end

  assign sum = (SUMW'(p_prod) <<< 1) + (SUMW'(i_sat) <<< 1) + SUMW'(d_prod);

endmodule

[verif/tb_vehicle_pid_throttle_brake_steer.sv]
`timescale 1ns / 1ps
// self-checking testbench for the throttle, brake and steering pid controller
module tb_vehicle_pid_throttle_brake_steer;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int N_DIRECTED = 22;
  localparam int N_SETTINGS = 9;
  localparam int ITEMS_PER_SETTING = 115;
  localparam int EXP_DEPTH = 16;
  localparam longint INTEG_MAX = 64'sd2147483647;
  localparam longint INTEG_MIN = -64'sd2147483648;

  // one input word, target_accel in the low bits
  typedef struct packed {
    logic        direct;
    logic [15:0] meas_str;
    logic [15:0] tgt_str;
    logic [15:0] meas_acc;
    logic [15:0] tgt_acc;
  } tick_in_t;

  // one result word, laid out as out_tdata[45:0]
  typedef struct packed {
    logic [15:0] steer;
    logic [14:0] brake;
    logic [14:0] throttle;
  } cmd_t;

  typedef struct packed {
    logic        fixed;
    logic        direct;
    logic [15:0] tgt_acc;
    logic [15:0] meas_acc;
    logic [15:0] tgt_str;
    logic [15:0] meas_str;
    logic [14:0] thr;
    logic [14:0] brk;
    logic [15:0] str;
  } row_t;

  // gains, deadzones, limits and period used by the directed rows
  localparam logic [47:0] DIRECTED_CFG [8] = '{
    48'h0020_0010_0100, 48'h0010_0008_0180, 48'h0040_0004_0100, 48'h0080_FF00_0100,
    48'h2000_0040, 48'h3000_0040, 48'h1800_0020, 48'd5
  };

  // fixed, direct, tgt_acc, meas_acc, tgt_str, meas_str, then throttle, brake, steer
  // where fixed is set
  localparam row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // inside the band right after reset: brake parked at its maximum
    '{1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 15'h0000, 15'h3000, 16'h0000},
    // largest positive accel error saturates the throttle
    '{1'b1, 1'b0, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 15'h2000, 15'h0000, 16'h0000},
    // largest negative accel error saturates the brake
    '{1'b1, 1'b0, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 15'h0000, 15'h3000, 16'h0000},
    // direct steer at both ends of the target range
    '{1'b1, 1'b1, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 15'h0000, 15'h3000, 16'h1800},
    '{1'b1, 1'b1, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 15'h0000, 15'h3000, 16'hE800},
    // deadzone edges, just on and just past
    '{1'b0, 1'b0, 16'h0100, 16'h0000, 16'h0080, 16'h0000, 15'h0, 15'h0, 16'h0},
    '{1'b0, 1'b0, 16'h0101, 16'h0000, 16'h0081, 16'h0000, 15'h0, 15'h0, 16'h0},
    '{1'b0, 1'b0, 16'h0000, 16'h0100, 16'h0000, 16'h0080, 15'h0, 15'h0, 16'h0},
    '{1'b0, 1'b0, 16'h0000, 16'h0101, 16'h0000, 16'h0081, 15'h0, 15'h0, 16'h0},
    // direct steer under, just over the minimum, and a floored minus one
    '{1'b0, 1'b1, 16'h0000, 16'h0000, 16'hFFF0, 16'h0000, 15'h0, 15'h0, 16'h0},
    '{1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0021, 16'h1234, 15'h0, 15'h0, 16'h0},
    '{1'b0, 1'b1, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 15'h0, 15'h0, 16'h0},
    // steer error saturating both ways
    '{1'b0, 1'b0, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 15'h0, 15'h0, 16'h0},
    '{1'b0, 1'b0, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 15'h0, 15'h0, 16'h0},
    // steady error runs the integrator across its clear
    '{1'b0, 1'b0, 16'h0200, 16'h0000, 16'h0000, 16'h0000, 15'h0, 15'h0, 16'h0},
    '{1'b0, 1'b0, 16'h0200, 16'h0000, 16'h0000, 16'h0000, 15'h0, 15'h0, 16'h0},
    '{1'b0, 1'b0, 16'h0200, 16'h0000, 16'h0000, 16'h0000, 15'h0, 15'h0, 16'h0},
    '{1'b0, 1'b0, 16'h0180, 16'h0040, 16'h0400, 16'h0100, 15'h0, 15'h0, 16'h0},
    '{1'b0, 1'b0, 16'hFE00, 16'h0000, 16'hFC00, 16'h0000, 15'h0, 15'h0, 16'h0},
    '{1'b0, 1'b0, 16'hFE00, 16'h0000, 16'hFC00, 16'h0000, 15'h0, 15'h0, 16'h0},
    '{1'b0, 1'b1, 16'h0000, 16'h0000, 16'h5555, 16'hAAAA, 15'h0, 15'h0, 16'h0},
    '{1'b0, 1'b0, 16'hAAAA, 16'h5555, 16'h0000, 16'h0000, 15'h0, 15'h0, 16'h0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // target_accel, measured_accel, target_steer, measured_steer
  logic [63:0] in_tdata = '0;
  // direct_mode
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // throttle_out, brake_out, steer_out, two zero pad bits
  logic [47:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_addr = '0;
  logic [47:0] cfg_data = '0;

  // travels with each input word: typed-in expectation, if any
  logic        word_fixed = 1'b0;
  cmd_t        word_want = '0;

  // results still owed, oldest at the read index
  cmd_t        exp_store [EXP_DEPTH];
  int          exp_wr = 0;
  int          exp_rd = 0;
  int          sent_cnt = 0;
  int          rcv_cnt = 0;
  int          n_err = 0;
  int          idle_cycles = 0;

  // controller copy: configuration
  vpid_pkg::gains_t thr_gains = '0;
  vpid_pkg::gains_t brk_gains = '0;
  vpid_pkg::gains_t str_gains = '0;
  logic [47:0] dz_cfg = '0;
  logic [31:0] thr_lim = '0;
  logic [31:0] brk_lim = '0;
  logic [31:0] str_lim = '0;
  logic [15:0] integ_steps = vpid_pkg::STEPS_RESET;

  // controller copy: state
  longint      acc_err_prev [2];
  longint      str_err_prev [2];
  int          err_count = 0;
  longint      tick = 0;
  longint      acc_int = 0;
  longint      str_int = 0;
  longint      thr_hold = 0;
  longint      brk_hold = 0;
  longint      str_hold = 0;
  bit          brk_parked = 1'b1;

  vehicle_pid_throttle_brake_steer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint pid_total(input vpid_pkg::gains_t g, input longint e,
                                       input longint integ, input longint slope);
    longint ki_term;
    ki_term = clamp(longint'(g.ki) * integ, -(64'sd1 <<< 40), 64'sd1 <<< 40);
    return 2 * longint'(g.kp) * e + 2 * ki_term + longint'(g.kd) * slope;
  endfunction

  // backward difference, order grows with the errors seen so far
  function automatic longint slope_of(input longint older, input longint last,
                                      input longint e);
    if (err_count >= 3) return older - 4 * last + 3 * e;
    if (err_count == 2) return 2 * (e - last);
    return 0;
  endfunction

  function automatic longint clip_pos(input longint v, input logic [31:0] l);
    longint hi;
    hi = longint'(l[30:16]);
    if (!(v > longint'(l[14:0]))) v = 0;
    return (v < hi) ? v : hi;
  endfunction

  function automatic longint clip_sym(input longint v, input logic [31:0] l);
    longint mag, hi;
    mag = (v < 0) ? -v : v;
    hi = longint'(l[30:16]);
    if (!(mag > longint'(l[14:0]))) return 0;
    if (mag > hi) return (v > 0) ? hi : -hi;
    return v;
  endfunction

  function automatic cmd_t ctl_step(input tick_in_t s);
    longint ea, es, da, ds, total, nxt;
    cmd_t c;
    ea = clamp(longint'($signed(s.tgt_acc)) - longint'($signed(s.meas_acc)), -32768, 32767);
    es = clamp(longint'($signed(s.tgt_str)) - longint'($signed(s.meas_str)), -32768, 32767);
    if (err_count < 3) err_count++;
    if (tick == 0) begin
      acc_int = 0;
      str_int = 0;
    end else begin
      acc_int = clamp(acc_int + ea, INTEG_MIN, INTEG_MAX);
      str_int = clamp(str_int + es, INTEG_MIN, INTEG_MAX);
    end
    da = slope_of(acc_err_prev[1], acc_err_prev[0], ea);
    ds = slope_of(str_err_prev[1], str_err_prev[0], es);
    acc_err_prev[1] = acc_err_prev[0];
    acc_err_prev[0] = ea;
    str_err_prev[1] = str_err_prev[0];
    str_err_prev[0] = es;

    if (ea > longint'($signed(dz_cfg[15:0]))) begin
      brk_hold = 0;
      brk_parked = 1'b0;
      total = pid_total(thr_gains, ea, acc_int, da);
      thr_hold = clip_pos(total >>> vpid_pkg::FRAC_SHIFT, thr_lim);
    end else if (ea < longint'($signed(dz_cfg[31:16]))) begin
      thr_hold = 0;
      brk_parked = 1'b0;
      total = pid_total(brk_gains, ea, acc_int, da);
      brk_hold = clip_pos((-total) >>> vpid_pkg::FRAC_SHIFT, brk_lim);
    end

    if (s.direct) begin
      total = longint'(str_gains.kp) * longint'($signed(s.tgt_str));
      str_hold = clip_sym(total >>> vpid_pkg::DIRECT_SHIFT, str_lim);
    end else if (((es < 0) ? -es : es) > longint'($signed(dz_cfg[47:32]))) begin
      total = pid_total(str_gains, es, str_int, ds);
      str_hold = clip_sym(total >>> vpid_pkg::FRAC_SHIFT, str_lim);
    end

    // wraps to zero at the period instead of a modulo
    nxt = tick + 1;
    if (nxt >= longint'(integ_steps)) nxt = 0;
    tick = nxt & 64'hFFFF;

    c.throttle = thr_hold[14:0];
    c.brake = brk_parked ? brk_lim[30:16] : brk_hold[14:0];
    c.steer = str_hold[15:0];
    return c;
  endfunction

  always @(posedge clk) begin : word_check
    cmd_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = cmd_t'(out_tdata[45:0]);
        rcv_cnt++;
        if (exp_wr == exp_rd) begin
          n_err++;
          if (n_err <= 10) $display("result word %0d with nothing expected: %h", rcv_cnt, got);
        end else begin
          want = exp_store[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (got.throttle !== want.throttle || got.brake !== want.brake ||
              got.steer !== want.steer) begin
            n_err++;
            if (n_err <= 10)
              $display("result word %0d (exp/got): throttle %h/%h brake %h/%h steer %h/%h",
                       rcv_cnt, want.throttle, got.throttle, want.brake, got.brake,
                       want.steer, got.steer);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        want = ctl_step({in_tuser, in_tdata});
        exp_store[exp_wr % EXP_DEPTH] = word_fixed ? word_want : want;
        exp_wr++;
      end
      if (cfg_valid && cfg_ready) begin
        case (vpid_pkg::cfg_reg_t'(cfg_addr))
          vpid_pkg::REG_THR_GAINS:   thr_gains = cfg_data;
          vpid_pkg::REG_BRK_GAINS:   brk_gains = cfg_data;
          vpid_pkg::REG_STR_GAINS:   str_gains = cfg_data;
          vpid_pkg::REG_DEADZONES:   dz_cfg = cfg_data;
          vpid_pkg::REG_THR_LIMITS:  thr_lim = cfg_data[31:0];
          vpid_pkg::REG_BRK_LIMITS:  brk_lim = cfg_data[31:0];
          vpid_pkg::REG_STR_LIMITS:  str_lim = cfg_data[31:0];
          vpid_pkg::REG_INTEG_STEPS: integ_steps = cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb_vehicle_pid_throttle_brake_steer: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, calm stretches, and two long hold-offs
  initial begin : result_sink
    int hold;
    int taken;
    taken = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken == 300 || taken == 800) hold = 90;
      else hold = (((taken / 64) % 3) != 0) ? $urandom_range(0, 13) : 0;
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      taken++;
    end
  end

  task automatic send_word(input tick_in_t s, input bit fixed, input cmd_t want);
    int gap;
    gap = (((sent_cnt / 50) % 3) != 0) ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= s[63:0];
    in_tuser <= s.direct;
    word_fixed <= fixed;
    word_want <= want;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_cnt++;
  endtask

  // stop offering and wait for every result to come back
  task automatic settle();
    in_tvalid <= 1'b0;
    while (rcv_cnt < sent_cnt) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input vpid_pkg::cfg_reg_t idx, input logic [47:0] val);
    cfg_addr <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [47:0] pick_gains();
    vpid_pkg::gains_t g;
    g.kp = 16'($urandom_range(0, 16'h0400));
    g.ki = 16'($urandom_range(0, 16'h0040));
    g.kd = 16'($urandom_range(0, 16'h0200));
    return g;
  endfunction

  function automatic logic [31:0] pick_limits();
    logic [31:0] l;
    l = $urandom;  // bits 15 and 31 are don't-care, left random
    l[14:0] = 15'($urandom_range(0, 16'h0200));
    l[30:16] = 15'($urandom_range(16'h0400, 16'h7FFF));
    return l;
  endfunction

  // -1 is the directed setting; 0 all ones, 1 all zero, 4 fully random words
  task automatic apply_setting(input int idx);
    logic [47:0] val [8];
    logic [15:0] dz_thr, dz_brk, dz_str;
    for (int r = 0; r < 8; r++) val[r] = '0;
    case (idx)
      -1: val = DIRECTED_CFG;
      0: for (int r = 0; r < 8; r++) val[r] = '1;
      1: ;
      4: for (int r = 0; r < 8; r++) val[r] = {16'($urandom), 32'($urandom)};
      default: begin
        dz_thr = 16'(int'($urandom_range(0, 16'h0600)) - 512);
        dz_brk = 16'(int'($urandom_range(0, 16'h0600)) - 1024);
        // negative steer deadzone keeps the steer pid always on
        dz_str = (idx == 2) ? 16'(-int'($urandom_range(1, 16'h0100)))
                            : 16'($urandom_range(0, 16'h0300));
        val[vpid_pkg::REG_THR_GAINS] = pick_gains();
        val[vpid_pkg::REG_BRK_GAINS] = pick_gains();
        val[vpid_pkg::REG_STR_GAINS] = pick_gains();
        val[vpid_pkg::REG_DEADZONES] = {dz_str, dz_brk, dz_thr};
        val[vpid_pkg::REG_THR_LIMITS] = pick_limits();
        val[vpid_pkg::REG_BRK_LIMITS] = pick_limits();
        val[vpid_pkg::REG_STR_LIMITS] = pick_limits();
        val[vpid_pkg::REG_INTEG_STEPS] = (idx == 2) ? 48'd1 :
                                         (idx == 3) ? 48'hFFFF : 48'($urandom_range(2, 40));
      end
    endcase
    for (int r = 0; r < 8; r++) write_reg(vpid_pkg::cfg_reg_t'(r), val[r]);
  endtask

  // mostly measured values tracking a target, some fully random words
  function automatic tick_in_t draw_item();
    tick_in_t s;
    int acc, str;
    if ($urandom_range(0, 4) == 0) begin
      s = {1'($urandom), 32'($urandom), 32'($urandom)};
    end else begin
      acc = int'($urandom_range(0, 16'h4000)) - 8192;
      str = int'($urandom_range(0, 16'h4000)) - 8192;
      s.tgt_acc = 16'(acc);
      s.meas_acc = 16'(acc - (int'($urandom_range(0, 16'h0C00)) - 1536));
      s.tgt_str = 16'(str);
      s.meas_str = 16'(str - (int'($urandom_range(0, 16'h0800)) - 1024));
      s.direct = ($urandom_range(0, 7) == 0);
    end
    return s;
  endfunction

  initial begin : stimulus
    tick_in_t s;
    cmd_t want;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apply_setting(-1);
    for (int i = 0; i < N_DIRECTED; i++) begin
      s.direct = DIRECTED_ROWS[i].direct;
      s.tgt_acc = DIRECTED_ROWS[i].tgt_acc;
      s.meas_acc = DIRECTED_ROWS[i].meas_acc;
      s.tgt_str = DIRECTED_ROWS[i].tgt_str;
      s.meas_str = DIRECTED_ROWS[i].meas_str;
      want = {DIRECTED_ROWS[i].str, DIRECTED_ROWS[i].brk, DIRECTED_ROWS[i].thr};
      send_word(s, DIRECTED_ROWS[i].fixed, want);
    end
    settle();

    for (int p = 0; p < N_SETTINGS; p++) begin
      apply_setting(p);
      for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
        if (i == ITEMS_PER_SETTING / 2) settle();
        send_word(draw_item(), 1'b0, '0);
      end
      settle();
    end

    if (n_err == 0 && exp_wr == exp_rd) begin
      $display("tb_vehicle_pid_throttle_brake_steer: PASS");
    end else begin
      $display("tb_vehicle_pid_throttle_brake_steer: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/vpid_pkg.sv
src/vpid_term.sv
src/vehicle_pid_throttle_brake_steer.sv
verif/tb_vehicle_pid_throttle_brake_steer.sv
